// ===== sv/tsb_pkg.sv =====
package tsb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_TICK_RATE        = 2'd0;
    localparam cfg_idx_t CFG_TICK_NANOSECONDS = 2'd1;
    localparam cfg_idx_t CFG_UNIX_BASE        = 2'd2;

    localparam int CFG_DATA_W = 34;

    // field widths
    localparam int RATE_W = 21;
    localparam int NS_W   = 30;
    localparam int SEC_W  = 32;
    localparam int BOOT_W = 34;
    localparam int UNIX_W = 35;
    localparam int WAKE_W = 16;

    localparam logic [RATE_W-1:0] TICK_RATE_RST = 21'd1000;
    localparam logic [NS_W-1:0]   TICK_NS_RST   = 30'd1000000;
    localparam logic [31:0]       NS_PER_SEC    = 32'd1000000000;

    // operation codes
    typedef logic [1:0] op_code_t;
    localparam op_code_t OP_TICK   = 2'd0;
    localparam op_code_t OP_ARM    = 2'd1;
    localparam op_code_t OP_CANCEL = 2'd2;

    typedef struct packed {
        op_code_t          operation;
        logic [3:0]        slot;
        logic [SEC_W-1:0]  sleep_seconds;
        logic [NS_W-1:0]   sleep_nanoseconds;
    } in_item_t;

    typedef struct packed {
        logic [WAKE_W-1:0] wake_mask;
        logic              second_pulse;
        logic [BOOT_W-1:0] seconds_since_boot;
        logic [UNIX_W-1:0] unix_seconds;
    } out_item_t;

    // remaining sleep time of one slot
    typedef struct packed {
        logic [SEC_W-1:0] seconds;
        logic [NS_W-1:0]  nanoseconds;
    } slot_time_t;

    typedef struct packed {
        logic       expired;
        slot_time_t remaining;
    } cd_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FIN
    } tsb_state_t;

endpackage

// ===== sv/tsb_slot_mem.sv =====
module tsb_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  tsb_pkg::slot_time_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output tsb_pkg::slot_time_t rdata
);

    tsb_pkg::slot_time_t mem [DEPTH];
    tsb_pkg::slot_time_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tsb_countdown.sv =====
module tsb_countdown (
    input  tsb_pkg::slot_time_t         cur,
    input  logic [tsb_pkg::NS_W-1:0]    dec,
    output tsb_pkg::cd_result_t         res
);

    logic [tsb_pkg::NS_W:0] ns_diff;
    logic [31:0]            borrow_ns;

    // ns - dec, sign bit says the nanoseconds fall short
    assign ns_diff = {1'b0, cur.nanoseconds} - {1'b0, dec};
    // one second borrowed: 1e9 - (dec - ns), negative means beyond a second
    assign borrow_ns = {2'b00, cur.nanoseconds} + tsb_pkg::NS_PER_SEC - {2'b00, dec};

    always_comb
    begin
        res.expired   = 1'b0;
        res.remaining = cur;
        if (!ns_diff[tsb_pkg::NS_W])
        begin
            res.remaining.nanoseconds = ns_diff[tsb_pkg::NS_W-1:0];
        end
        else if (cur.seconds == '0)
        begin
            res.expired               = 1'b1;
            res.remaining.nanoseconds = '0;
        end
        else
        begin
            res.remaining.seconds     = cur.seconds - 32'd1;
            res.remaining.nanoseconds = borrow_ns[31] ? '0 : borrow_ns[tsb_pkg::NS_W-1:0];
        end
    end

endmodule

// ===== sv/tick_sleep_timer_bank.sv =====
// Tick unit with a bank of SLOTS sleep countdown timers. Every input item
// gives exactly one result item. A tick item advances the prescaler, bumps
// the seconds counters once tick_rate ticks have gone by, and walks every
// slot of the timer memory subtracting tick_nanoseconds from armed slots;
// slots that run out are disarmed and flagged in wake_mask (slots sixteen
// and up expire silently). A tick holds off new items until it has swept
// every slot and passed the finish state; the sweep runs through the single
// read port of the slot time memory, one slot a cycle, with write-back in the
// cycle after the read. Arm and cancel items go straight to the finish state.
// A finished result waits in an output register, so the next item is taken
// while the previous result is still pending. Slot times are undefined until
// armed; the armed bits are flip-flops cleared by reset. Configuration
// writes must only be issued while the block is idle.
module tick_sleep_timer_bank #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tsb_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tsb_pkg::out_item_t                out_data,
    input  logic                              cfg_we,
    input  tsb_pkg::cfg_idx_t                 cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // configuration registers
    logic [tsb_pkg::RATE_W-1:0] tick_rate_reg;
    logic [tsb_pkg::NS_W-1:0]   tick_ns_reg;
    logic [tsb_pkg::BOOT_W-1:0] unix_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= tsb_pkg::TICK_RATE_RST;
            tick_ns_reg   <= tsb_pkg::TICK_NS_RST;
            unix_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsb_pkg::CFG_TICK_RATE:
                begin
                    tick_rate_reg <= cfg_data[tsb_pkg::RATE_W-1:0];
                end
                tsb_pkg::CFG_TICK_NANOSECONDS:
                begin
                    tick_ns_reg <= cfg_data[tsb_pkg::NS_W-1:0];
                end
                tsb_pkg::CFG_UNIX_BASE:
                begin
                    unix_base_reg <= cfg_data[tsb_pkg::BOOT_W-1:0];
                end
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // control and counter state
    tsb_pkg::tsb_state_t         state_reg, state_next;
    logic [CNT_W-1:0]            rd_cnt_reg, rd_cnt_next;
    logic                        p_vld_reg, p_vld_next;
    logic [SLOT_W-1:0]           p_idx_reg, p_idx_next;
    logic [SLOTS-1:0]            armed_reg, armed_next;
    logic [tsb_pkg::RATE_W-1:0]  tick_cnt_reg, tick_cnt_next;
    logic [tsb_pkg::BOOT_W-1:0]  elapsed_reg, elapsed_next;
    logic [tsb_pkg::WAKE_W-1:0]  wake_reg, wake_next;
    logic                        pulse_reg, pulse_next;
    logic                        out_valid_reg, out_valid_next;
    tsb_pkg::out_item_t          out_data_reg, out_data_next;

    // memory port signals
    logic                        mem_we;
    logic [SLOT_W-1:0]           mem_waddr;
    tsb_pkg::slot_time_t         mem_wdata;
    logic                        mem_re;
    tsb_pkg::slot_time_t         mem_rdata;
    tsb_pkg::cd_result_t         cd_res;

    logic                        in_accept;
    logic                        slot_in_range;
    logic [SLOT_W-1:0]           in_slot_idx;
    logic [tsb_pkg::RATE_W-1:0]  tick_inc;
    logic                        issue;

    assign in_ready      = (state_reg == tsb_pkg::ST_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign slot_in_range = (32'(in_data.slot) < SLOTS);
    assign in_slot_idx   = SLOT_W'(in_data.slot);
    assign tick_inc      = tick_cnt_reg + 21'd1;
    assign issue         = (state_reg == tsb_pkg::ST_SWEEP) && (rd_cnt_reg < CNT_W'(SLOTS));
    assign mem_re        = issue;

    tsb_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_cnt_reg[SLOT_W-1:0]),
        .rdata (mem_rdata)
    );

    tsb_countdown u_countdown (
        .cur (mem_rdata),
        .dec (tick_ns_reg),
        .res (cd_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = p_idx_reg;
        armed_next     = armed_reg;
        tick_cnt_next  = tick_cnt_reg;
        elapsed_next   = elapsed_reg;
        wake_next      = wake_reg;
        pulse_next     = pulse_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = in_slot_idx;
        mem_wdata      = '{seconds: in_data.sleep_seconds,
                           nanoseconds: in_data.sleep_nanoseconds};

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tsb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    wake_next  = '0;
                    pulse_next = 1'b0;
                    state_next = tsb_pkg::ST_FIN;
                    case (in_data.operation)
                        tsb_pkg::OP_TICK:
                        begin
                            // prescaler; a rate below the count completes at once
                            if (tick_inc >= tick_rate_reg)
                            begin
                                tick_cnt_next = '0;
                                elapsed_next  = elapsed_reg + 34'd1;
                                pulse_next    = 1'b1;
                            end
                            else
                            begin
                                tick_cnt_next = tick_inc;
                            end
                            rd_cnt_next = '0;
                            state_next  = tsb_pkg::ST_SWEEP;
                        end
                        tsb_pkg::OP_ARM:
                        begin
                            if (slot_in_range)
                            begin
                                mem_we                  = 1'b1;
                                armed_next[in_slot_idx] = 1'b1;
                            end
                        end
                        tsb_pkg::OP_CANCEL:
                        begin
                            if (slot_in_range)
                            begin
                                armed_next[in_slot_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unused operation: report only
                        end
                    endcase
                end
            end

            tsb_pkg::ST_SWEEP:
            begin
                // read stage: one slot address a cycle
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_cnt_reg[SLOT_W-1:0];
                end
                else
                begin
                    state_next = tsb_pkg::ST_FIN;
                end
                // update stage: count down the slot read last cycle
                if (p_vld_reg && armed_reg[p_idx_reg])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = p_idx_reg;
                    mem_wdata = cd_res.remaining;
                    if (cd_res.expired)
                    begin
                        armed_next[p_idx_reg] = 1'b0;
                        // slots past the mask width shift out
                        wake_next = wake_reg | (tsb_pkg::WAKE_W'(1) << p_idx_reg);
                    end
                end
            end

            tsb_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.wake_mask          = wake_reg;
                    out_data_next.second_pulse       = pulse_reg;
                    out_data_next.seconds_since_boot = elapsed_reg;
                    out_data_next.unix_seconds       = tsb_pkg::UNIX_W'(unix_base_reg)
                                                     + tsb_pkg::UNIX_W'(elapsed_reg);
                    state_next                       = tsb_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsb_pkg::ST_IDLE;
            rd_cnt_reg    <= '0;
            p_vld_reg     <= 1'b0;
            armed_reg     <= '0;
            tick_cnt_reg  <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            p_vld_reg     <= p_vld_next;
            armed_reg     <= armed_next;
            tick_cnt_reg  <= tick_cnt_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_idx_reg    <= p_idx_next;
        wake_reg     <= wake_next;
        pulse_reg    <= pulse_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    // sweep counter never runs past the bank
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(SLOTS))
        else $error("sweep counter past slot count");

    // a tick starts a sweep from slot zero
    a_tick_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.operation == tsb_pkg::OP_TICK) |=>
        (state_reg == tsb_pkg::ST_SWEEP && rd_cnt_reg == '0))
        else $error("tick did not start sweep");

    // update stage only active inside a sweep
    a_pvld_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> state_reg == tsb_pkg::ST_SWEEP)
        else $error("update stage outside sweep");

    // an accepted arm leaves its slot armed
    a_arm_set: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.operation == tsb_pkg::OP_ARM && slot_in_range) |=>
        armed_reg[$past(in_slot_idx)])
        else $error("arm did not set armed bit");

    // a new result only comes out of the finish state
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tsb_pkg::ST_FIN))
        else $error("result loaded outside finish state");
`endif

endmodule
